/* hdl/htnc_pkg.sv */
// ---------------------------------------------------------------------------
// htnc_pkg
// Shared types, constants and the tag classifier of the tag nesting checker.
// ---------------------------------------------------------------------------
`default_nettype none

package htnc_pkg;

    localparam int STACK_DEPTH   = 64;
    localparam int MAX_TAG_CHARS = 7;
    localparam int TEXT_CHARS    = 7;
    localparam int TEXT_W        = 8 * TEXT_CHARS;
    localparam int CNT_W         = $clog2(STACK_DEPTH + 1);
    localparam int NUM_TAGS      = 10;
    localparam int NAME_CHARS    = 4;
    localparam int OUT_W         = 48;

    localparam logic [7:0] CHAR_LT    = 8'h3C;
    localparam logic [7:0] CHAR_GT    = 8'h3E;
    localparam logic [7:0] CHAR_SLASH = 8'h2F;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_NL    = 8'h0A;

    localparam logic [2:0] ERR_NONE       = 3'd0;
    localparam logic [2:0] ERR_UNKNOWN    = 3'd1;
    localparam logic [2:0] ERR_MISMATCH   = 3'd2;
    localparam logic [2:0] ERR_EMPTY_POP  = 3'd3;
    localparam logic [2:0] ERR_OVERFLOW   = 3'd4;
    localparam logic [2:0] ERR_UNTERM     = 3'd5;
    localparam logic [2:0] ERR_UNCLOSED   = 3'd6;

    localparam logic [3:0] UNKNOWN_CODE = 4'd10;
    localparam logic [3:0] NO_CODE      = 4'd0;

    // html head body p br li h1 h2 ul ol
    localparam logic [7:0] TAG_NAME [NUM_TAGS][NAME_CHARS] = '{
        '{"h", "t", "m", "l"},
        '{"h", "e", "a", "d"},
        '{"b", "o", "d", "y"},
        '{"p", 8'h00, 8'h00, 8'h00},
        '{"b", "r", 8'h00, 8'h00},
        '{"l", "i", 8'h00, 8'h00},
        '{"h", "1", 8'h00, 8'h00},
        '{"h", "2", 8'h00, 8'h00},
        '{"u", "l", 8'h00, 8'h00},
        '{"o", "l", 8'h00, 8'h00}
    };
    localparam logic [3:0] TAG_LEN [NUM_TAGS] = '{
        4'd4, 4'd4, 4'd4, 4'd1, 4'd2, 4'd2, 4'd2, 4'd2, 4'd2, 4'd2
    };

    typedef enum logic [1:0] {
        KIND_UNKNOWN = 2'd0,
        KIND_OPEN    = 2'd1,
        KIND_CLOSE   = 2'd2,
        KIND_EMPTY   = 2'd3
    } tag_kind_t;

    typedef struct packed {
        tag_kind_t  kind;
        logic [3:0] code;
    } tag_class_t;

    typedef struct packed {
        logic [3:0]  code;
        logic [31:0] pos;
    } entry_t;

    typedef struct packed {
        logic push;
        logic pop;
    } shift_t;

    typedef struct packed {
        shift_t shift;
        logic   clear;
    } stack_ctrl_t;

    // packed from the top bit down; is_valid is bit 0
    typedef struct packed {
        logic [6:0]  open_count;
        logic [3:0]  error_tag;
        logic [31:0] error_position;
        logic [2:0]  error_kind;
        logic        is_valid;
    } result_t;

    function automatic tag_class_t classify(input logic [TEXT_W-1:0] text,
                                            input logic [3:0] len);
        tag_class_t r;
        logic [7:0] ch [TEXT_CHARS];
        logic [7:0] last_ch;
        logic       is_close;
        logic [3:0] first;
        logic [3:0] nlen;
        logic       same;
        r.kind   = KIND_UNKNOWN;
        r.code   = UNKNOWN_CODE;
        last_ch  = 8'h00;
        for (int i = 0; i < TEXT_CHARS; i++)
        begin
            ch[i] = text[8*i +: 8];
            if (4'(i) == len - 4'd1)
            begin
                last_ch = ch[i];
            end
        end
        is_close = (ch[1] == CHAR_SLASH);
        first    = is_close ? 4'd2 : 4'd1;
        nlen     = len - 4'd1 - first;
        if (len >= 4'd3 && int'(len) <= MAX_TAG_CHARS && int'(len) <= TEXT_CHARS &&
            ch[0] == CHAR_LT && last_ch == CHAR_GT)
        begin
            if (len == 4'd5 && ch[1] == "b" && ch[2] == "r" && ch[3] == CHAR_SLASH)
            begin
                r.kind = KIND_EMPTY;
            end
            else if (len >= first + 4'd2)
            begin
                for (int k = NUM_TAGS - 1; k >= 0; k--)
                begin
                    same = (nlen == TAG_LEN[k]);
                    for (int j = 0; j < NAME_CHARS; j++)
                    begin
                        if (4'(j) < TAG_LEN[k])
                        begin
                            if ((is_close ? ch[2+j] : ch[1+j]) != TAG_NAME[k][j])
                            begin
                                same = 1'b0;
                            end
                        end
                    end
                    if (same)
                    begin
                        r.kind = is_close ? KIND_CLOSE : KIND_OPEN;
                        r.code = 4'(k);
                    end
                end
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* hdl/htnc_cell.sv */
// ---------------------------------------------------------------------------
// htnc_cell
// One stack cell: loads from the upper neighbor on push, the lower on pop.
// ---------------------------------------------------------------------------
`default_nettype none

module htnc_cell (
    input  wire                 clk,
    input  htnc_pkg::shift_t    shift,
    input  htnc_pkg::entry_t    upper,
    input  htnc_pkg::entry_t    lower,
    output htnc_pkg::entry_t    q
);

    htnc_pkg::entry_t entry_reg;
    htnc_pkg::entry_t entry_next;

    always_comb
    begin
        entry_next = entry_reg;
        if (shift.push)
        begin
            entry_next = upper;
        end
        else if (shift.pop)
        begin
            entry_next = lower;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign q = entry_reg;

endmodule

`default_nettype wire

/* hdl/htnc_stack.sv */
// ---------------------------------------------------------------------------
// htnc_stack
// Shifting tag stack: a row of cells, top in cell 0, plus the fill count.
// ---------------------------------------------------------------------------
`default_nettype none

module htnc_stack (
    input  wire                             clk,
    input  wire                             rst_n,
    input  htnc_pkg::stack_ctrl_t           ctrl,
    input  htnc_pkg::entry_t                new_entry,
    output htnc_pkg::entry_t                top,
    output htnc_pkg::entry_t                second,
    output logic [htnc_pkg::CNT_W-1:0]      count
);

    htnc_pkg::entry_t cells [htnc_pkg::STACK_DEPTH];

    logic [htnc_pkg::CNT_W-1:0] count_reg;
    logic [htnc_pkg::CNT_W-1:0] count_next;

    genvar i;
    generate
        for (i = 0; i < htnc_pkg::STACK_DEPTH; i++)
        begin : g_cell
            htnc_pkg::entry_t upper;
            htnc_pkg::entry_t lower;
            if (i == 0)
            begin : g_first
                assign upper = new_entry;
            end
            else
            begin : g_mid_up
                assign upper = cells[i-1];
            end
            if (i == htnc_pkg::STACK_DEPTH - 1)
            begin : g_last
                assign lower = cells[i];
            end
            else
            begin : g_mid_dn
                assign lower = cells[i+1];
            end
            htnc_cell u_cell (
                .clk   (clk),
                .shift (ctrl.shift),
                .upper (upper),
                .lower (lower),
                .q     (cells[i])
            );
        end
    endgenerate

    always_comb
    begin
        count_next = count_reg;
        if (ctrl.clear)
        begin
            count_next = '0;
        end
        else if (ctrl.shift.push)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (ctrl.shift.pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    assign top    = cells[0];
    assign second = cells[1];
    assign count  = count_reg;

endmodule

`default_nettype wire

/* hdl/htnc_out_queue.sv */
// ---------------------------------------------------------------------------
// htnc_out_queue
// Two-entry result queue: output register plus skid entry.
// ---------------------------------------------------------------------------
`default_nettype none

module htnc_out_queue (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 push,
    input  htnc_pkg::result_t   din,
    input  wire                 out_ready,
    output logic                out_valid,
    output htnc_pkg::result_t   dout,
    output logic                full
);

    htnc_pkg::result_t q0_reg;
    htnc_pkg::result_t q0_next;
    htnc_pkg::result_t q1_reg;
    htnc_pkg::result_t q1_next;
    logic              v0_reg;
    logic              v0_next;
    logic              v1_reg;
    logic              v1_next;
    logic              pop;

    assign pop = v0_reg && out_ready;

    always_comb
    begin
        q0_next = q0_reg;
        q1_next = q1_reg;
        v0_next = v0_reg;
        v1_next = v1_reg;
        if (pop)
        begin
            q0_next = q1_reg;
            v0_next = v1_reg;
            v1_next = 1'b0;
            if (push)
            begin
                if (v1_reg)
                begin
                    q1_next = din;
                    v1_next = 1'b1;
                end
                else
                begin
                    q0_next = din;
                    v0_next = 1'b1;
                end
            end
        end
        else if (push)
        begin
            if (!v0_reg)
            begin
                q0_next = din;
                v0_next = 1'b1;
            end
            else
            begin
                q1_next = din;
                v1_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
        end
        else
        begin
            v0_reg <= v0_next;
            v1_reg <= v1_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q0_reg <= q0_next;
        q1_reg <= q1_next;
    end

    assign out_valid = v0_reg;
    assign dout      = q0_reg;
    assign full      = v1_reg;

endmodule

`default_nettype wire

/* hdl/html_tag_nesting_checker.sv */
// ---------------------------------------------------------------------------
// html_tag_nesting_checker
// Byte-stream tag nesting check with a shifting stack of cells.
// ---------------------------------------------------------------------------
// Throughput: one byte beat per cycle while the result queue is not full; tag
//   compare and stack shift both finish in the cycle the beat is accepted.
// Output: a result is registered into the result queue and is put on m_tdata once the older results have been taken.
// Reset: rst_n clears count, scanner state and queue flags; stack cells are
//   never cleared, the fill count keeps unwritten cells from being read.
`default_nettype none

module html_tag_nesting_checker (
    input  wire                             clk,
    input  wire                             rst_n,
    input  wire                             s_tvalid,
    output logic                            s_tready,
    input  wire  [7:0]                      s_tdata,   // data_byte
    input  wire                             s_tlast,   // last_byte
    output logic                            m_tvalid,
    input  wire                             m_tready,
    // is_valid, error_kind[3], error_position[32], error_tag[4], open_count[7]
    output logic [htnc_pkg::OUT_W-1:0]      m_tdata
);

    logic [31:0]                  offset_reg;
    logic [31:0]                  offset_next;
    logic                         inside_reg;
    logic                         inside_next;
    logic [htnc_pkg::TEXT_W-1:0]  text_reg;
    logic [htnc_pkg::TEXT_W-1:0]  text_next;
    logic [3:0]                   len_reg;
    logic [3:0]                   len_next;
    logic [31:0]                  start_reg;
    logic [31:0]                  start_next;
    logic                         err_reg;
    logic                         err_next;

    logic [htnc_pkg::TEXT_W-1:0]  text_upd;
    logic [3:0]                   len_upd;
    logic [7:0]                   folded;
    logic                         accept;
    logic                         emit;
    logic                         queue_full;

    htnc_pkg::tag_class_t         cls;
    htnc_pkg::stack_ctrl_t        ctrl;
    htnc_pkg::entry_t             new_entry;
    htnc_pkg::entry_t             top;
    htnc_pkg::entry_t             second;
    htnc_pkg::entry_t             top_after;
    htnc_pkg::result_t            res;
    htnc_pkg::result_t            head;
    logic [htnc_pkg::CNT_W-1:0]   count;
    logic [htnc_pkg::CNT_W-1:0]   count_after;

    assign s_tready  = !queue_full;
    assign accept    = s_tvalid && s_tready;
    assign new_entry = '{code: cls.code, pos: start_reg};
    assign folded    = (s_tdata inside {[8'h41:8'h5A]}) ? s_tdata + 8'd32 : s_tdata;
    assign cls       = htnc_pkg::classify(text_upd, len_upd);

    always_comb
    begin
        text_upd = text_reg;
        for (int i = 0; i < htnc_pkg::TEXT_CHARS; i++)
        begin
            if (len_reg == 4'(i))
            begin
                text_upd[8*i +: 8] = text_reg[8*i +: 8] | folded;
            end
        end
        len_upd = (len_reg == 4'd15) ? len_reg : len_reg + 4'd1;
    end

    always_comb
    begin
        offset_next = offset_reg;
        inside_next = inside_reg;
        text_next   = text_reg;
        len_next    = len_reg;
        start_next  = start_reg;
        err_next    = err_reg;
        ctrl        = '0;
        emit        = 1'b0;
        res         = '0;
        count_after = count;
        top_after   = top;
        if (accept)
        begin
            if (!err_reg && s_tdata != htnc_pkg::CHAR_SPACE && s_tdata != htnc_pkg::CHAR_NL)
            begin
                if (offset_reg != 32'hFFFF_FFFF)
                begin
                    offset_next = offset_reg + 32'd1;
                end
                if (!inside_reg)
                begin
                    if (s_tdata == htnc_pkg::CHAR_LT)
                    begin
                        inside_next = 1'b1;
                        start_next  = offset_reg;
                        text_next   = htnc_pkg::TEXT_W'(htnc_pkg::CHAR_LT);
                        len_next    = 4'd1;
                    end
                end
                else
                begin
                    text_next = text_upd;
                    len_next  = len_upd;
                    if (s_tdata == htnc_pkg::CHAR_GT)
                    begin
                        inside_next = 1'b0;
                        case (cls.kind)
                            htnc_pkg::KIND_UNKNOWN:
                            begin
                                emit               = 1'b1;
                                res.error_kind     = htnc_pkg::ERR_UNKNOWN;
                                res.error_position = start_reg;
                                res.error_tag      = htnc_pkg::UNKNOWN_CODE;
                            end
                            htnc_pkg::KIND_OPEN:
                            begin
                                if (int'(count) >= htnc_pkg::STACK_DEPTH)
                                begin
                                    emit               = 1'b1;
                                    res.error_kind     = htnc_pkg::ERR_OVERFLOW;
                                    res.error_position = start_reg;
                                    res.error_tag      = cls.code;
                                end
                                else
                                begin
                                    ctrl.shift.push = 1'b1;
                                end
                            end
                            htnc_pkg::KIND_CLOSE:
                            begin
                                if (count == '0)
                                begin
                                    emit               = 1'b1;
                                    res.error_kind     = htnc_pkg::ERR_EMPTY_POP;
                                    res.error_position = start_reg;
                                    res.error_tag      = cls.code;
                                end
                                else if (top.code != cls.code)
                                begin
                                    emit               = 1'b1;
                                    res.error_kind     = htnc_pkg::ERR_MISMATCH;
                                    res.error_position = start_reg;
                                    res.error_tag      = cls.code;
                                end
                                else
                                begin
                                    ctrl.shift.pop = 1'b1;
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
            end

            if (ctrl.shift.push)
            begin
                count_after = count + 1'b1;
                top_after   = new_entry;
            end
            else if (ctrl.shift.pop)
            begin
                count_after = count - 1'b1;
                top_after   = second;
            end

            if (s_tlast)
            begin
                if (!emit && !err_reg)
                begin
                    emit = 1'b1;
                    if (inside_next)
                    begin
                        res.error_kind     = htnc_pkg::ERR_UNTERM;
                        res.error_position = start_next;
                        res.error_tag      = htnc_pkg::UNKNOWN_CODE;
                    end
                    else if (count_after != '0)
                    begin
                        res.error_kind     = htnc_pkg::ERR_UNCLOSED;
                        res.error_position = top_after.pos;
                        res.error_tag      = top_after.code;
                    end
                    else
                    begin
                        res.is_valid       = 1'b1;
                        res.error_kind     = htnc_pkg::ERR_NONE;
                        res.error_position = 32'd0;
                        res.error_tag      = htnc_pkg::NO_CODE;
                    end
                end
                ctrl.clear  = 1'b1;
                offset_next = 32'd0;
                inside_next = 1'b0;
                text_next   = '0;
                len_next    = 4'd0;
                start_next  = 32'd0;
                err_next    = 1'b0;
            end
            else if (emit)
            begin
                err_next = 1'b1;
            end
            res.open_count = 7'(count_after);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg <= 32'd0;
            inside_reg <= 1'b0;
            text_reg   <= '0;
            len_reg    <= 4'd0;
            start_reg  <= 32'd0;
            err_reg    <= 1'b0;
        end
        else
        begin
            offset_reg <= offset_next;
            inside_reg <= inside_next;
            text_reg   <= text_next;
            len_reg    <= len_next;
            start_reg  <= start_next;
            err_reg    <= err_next;
        end
    end

    htnc_stack u_stack (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .new_entry (new_entry),
        .top       (top),
        .second    (second),
        .count     (count)
    );

    htnc_out_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (emit),
        .din       (res),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .dout      (head),
        .full      (queue_full)
    );

    assign m_tdata = {1'b0, head};

endmodule

`default_nettype wire

/* test/tb.sv */
// ---------------------------------------------------------------------------
// tb
// Byte-stream test of html_tag_nesting_checker. Documents are queued as
// beats: a few hand-written ones for the corner cases, then random
// documents built from real open/close tags with random case, dropped
// whitespace, plain text, deep stacks and broken or unknown tags mixed in.
// Each accepted beat runs through a local nesting predictor; every result
// beat is checked field by field against the oldest predicted verdict.
// ---------------------------------------------------------------------------
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } beat_t;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [7:0]                    s_tdata = 8'h00;
    logic                          s_tlast = 1'b0;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [htnc_pkg::OUT_W-1:0]    m_tdata;

    html_tag_nesting_checker i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #4 clk = ~clk;

    string known_names [htnc_pkg::NUM_TAGS] = '{"html", "head", "body", "p", "br",
                                                "li", "h1", "h2", "ul", "ol"};
    string odd_tags [9] = '{"<div>", "<header>", "<h3>", "<brr>", "<>", "</>",
                            "<b/r>", "<p<>", "<br/ >"};

    beat_t                 beats_to_send [$];
    htnc_pkg::result_t     verdicts_due [$];
    logic [7:0]            doc_bytes [$];
    int                    open_codes [$];
    bit                    first_deep = 1'b1;

    // predictor state
    logic [3:0]  stk_code [htnc_pkg::STACK_DEPTH];
    logic [31:0] stk_pos [htnc_pkg::STACK_DEPTH];
    int          depth = 0;
    logic [31:0] offset = '0;
    logic        in_tag = 1'b0;
    logic [htnc_pkg::TEXT_W-1:0] txt = '0;
    logic [3:0]  txt_len = '0;
    logic [31:0] tag_pos = '0;
    logic        latched = 1'b0;

    int                 fault_cnt = 0;
    int                 cycle_cnt = 0;
    int                 cycle_limit = 2000000;
    int                 send_gap = 0;
    int                 sink_hold = 0;
    int                 stall;
    bit                 calm_in = 1'b0;
    bit                 calm_out = 1'b0;
    beat_t              nxt_beat;
    htnc_pkg::result_t  got;
    htnc_pkg::result_t  want;

    function automatic void note_fault(string msg);
        fault_cnt++;
        if (fault_cnt <= 10)
        begin
            $display("%0t: %s", $realtime, msg);
        end
    endfunction

    function automatic void add_byte(logic [7:0] b);
        doc_bytes.insert(doc_bytes.size(), b);
    endfunction

    function automatic void classify_tag(output htnc_pkg::tag_kind_t kind,
                                         output logic [3:0] code);
        logic [7:0] ch [8];
        int         len;
        int         first;
        int         nlen;
        logic       same;
        for (int i = 0; i < htnc_pkg::TEXT_CHARS; i++)
        begin
            ch[i] = txt[8*i +: 8];
        end
        ch[7] = 8'h00;
        kind  = htnc_pkg::KIND_UNKNOWN;
        code  = htnc_pkg::UNKNOWN_CODE;
        len   = txt_len;
        if (len < 3 || len > htnc_pkg::MAX_TAG_CHARS || len > htnc_pkg::TEXT_CHARS)
        begin
            return;
        end
        if (ch[0] != htnc_pkg::CHAR_LT || ch[len-1] != htnc_pkg::CHAR_GT)
        begin
            return;
        end
        if (len == 5 && ch[1] == "b" && ch[2] == "r" && ch[3] == htnc_pkg::CHAR_SLASH)
        begin
            kind = htnc_pkg::KIND_EMPTY;
            return;
        end
        first = (ch[1] == htnc_pkg::CHAR_SLASH) ? 2 : 1;
        if (len < first + 2)
        begin
            return;
        end
        nlen = len - 1 - first;
        for (int k = 0; k < htnc_pkg::NUM_TAGS; k++)
        begin
            if (kind == htnc_pkg::KIND_UNKNOWN && known_names[k].len() == nlen)
            begin
                same = 1'b1;
                for (int j = 0; j < nlen; j++)
                begin
                    if (ch[first+j] != known_names[k][j])
                    begin
                        same = 1'b0;
                    end
                end
                if (same)
                begin
                    kind = (first == 2) ? htnc_pkg::KIND_CLOSE : htnc_pkg::KIND_OPEN;
                    code = 4'(k);
                end
            end
        end
    endfunction

    function automatic htnc_pkg::result_t make_verdict(logic [2:0] kind, logic [31:0] pos,
                                                       logic [3:0] code);
        htnc_pkg::result_t r;
        r.is_valid       = (kind == htnc_pkg::ERR_NONE);
        r.error_kind     = kind;
        r.error_position = pos;
        r.error_tag      = code;
        r.open_count     = 7'(depth);
        latched          = 1'b1;
        return r;
    endfunction

    function automatic void predict_nesting(logic [7:0] b, logic lst);
        htnc_pkg::result_t    r;
        logic                 hit;
        logic [31:0]          pos;
        logic [7:0]           c;
        htnc_pkg::tag_kind_t  kind;
        logic [3:0]           code;
        hit = 1'b0;
        r   = '0;
        if (!latched && b != htnc_pkg::CHAR_SPACE && b != htnc_pkg::CHAR_NL)
        begin
            pos = offset;
            if (offset != '1)
            begin
                offset++;
            end
            if (!in_tag)
            begin
                if (b == htnc_pkg::CHAR_LT)
                begin
                    in_tag  = 1'b1;
                    tag_pos = pos;
                    txt     = htnc_pkg::TEXT_W'(htnc_pkg::CHAR_LT);
                    txt_len = 4'd1;
                end
            end
            else
            begin
                c = (b >= "A" && b <= "Z") ? b + 8'd32 : b;
                if (txt_len < 4'd7)
                begin
                    txt[8*txt_len +: 8] = c;
                end
                if (txt_len < 4'd15)
                begin
                    txt_len++;
                end
                if (b == htnc_pkg::CHAR_GT)
                begin
                    classify_tag(kind, code);
                    in_tag = 1'b0;
                    case (kind)
                        htnc_pkg::KIND_UNKNOWN:
                        begin
                            r   = make_verdict(htnc_pkg::ERR_UNKNOWN, tag_pos,
                                               htnc_pkg::UNKNOWN_CODE);
                            hit = 1'b1;
                        end
                        htnc_pkg::KIND_OPEN:
                        begin
                            if (depth >= htnc_pkg::STACK_DEPTH)
                            begin
                                r   = make_verdict(htnc_pkg::ERR_OVERFLOW, tag_pos, code);
                                hit = 1'b1;
                            end
                            else
                            begin
                                stk_code[depth] = code;
                                stk_pos[depth]  = tag_pos;
                                depth++;
                            end
                        end
                        htnc_pkg::KIND_CLOSE:
                        begin
                            if (depth == 0)
                            begin
                                r   = make_verdict(htnc_pkg::ERR_EMPTY_POP, tag_pos, code);
                                hit = 1'b1;
                            end
                            else if (stk_code[depth-1] != code)
                            begin
                                r   = make_verdict(htnc_pkg::ERR_MISMATCH, tag_pos, code);
                                hit = 1'b1;
                            end
                            else
                            begin
                                depth--;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
        end
        if (lst)
        begin
            if (!hit && !latched)
            begin
                if (in_tag)
                begin
                    r = make_verdict(htnc_pkg::ERR_UNTERM, tag_pos, htnc_pkg::UNKNOWN_CODE);
                end
                else if (depth > 0)
                begin
                    r = make_verdict(htnc_pkg::ERR_UNCLOSED, stk_pos[depth-1],
                                     stk_code[depth-1]);
                end
                else
                begin
                    r = make_verdict(htnc_pkg::ERR_NONE, '0, htnc_pkg::NO_CODE);
                end
                hit = 1'b1;
            end
            depth   = 0;
            offset  = '0;
            in_tag  = 1'b0;
            txt     = '0;
            txt_len = '0;
            tag_pos = '0;
            latched = 1'b0;
        end
        if (hit)
        begin
            verdicts_due.insert(verdicts_due.size(), r);
        end
    endfunction

    // scramble: random letter case and dropped whitespace between characters
    function automatic void add_text(string s, bit scramble);
        logic [7:0] c;
        for (int i = 0; i < s.len(); i++)
        begin
            c = s[i];
            if (scramble && c >= "a" && c <= "z" && $urandom_range(0, 3) == 0)
            begin
                c = c - 8'd32;
            end
            add_byte(c);
            if (scramble && $urandom_range(0, 9) == 0)
            begin
                add_byte($urandom_range(0, 1) ? htnc_pkg::CHAR_SPACE : htnc_pkg::CHAR_NL);
            end
        end
    endfunction

    function automatic void ship_doc();
        beat_t bt;
        for (int i = 0; i < doc_bytes.size(); i++)
        begin
            bt.data = doc_bytes[i];
            bt.last = (i == doc_bytes.size() - 1);
            beats_to_send.insert(beats_to_send.size(), bt);
        end
        doc_bytes.delete();
    endfunction

    function automatic void add_open(int c);
        add_text({"<", known_names[c], ">"}, 1'b1);
        open_codes.insert(open_codes.size(), c);
    endfunction

    function automatic void gen_document();
        int         n_elem;
        int         c;
        int         pick;
        logic [7:0] v;
        open_codes.delete();
        if (first_deep || $urandom_range(0, 99) < 3)
        begin
            first_deep = 1'b0;
            n_elem = $urandom_range(htnc_pkg::STACK_DEPTH - 2, htnc_pkg::STACK_DEPTH + 2);
            for (int i = 0; i < n_elem; i++)
            begin
                add_open($urandom_range(0, htnc_pkg::NUM_TAGS - 1));
            end
        end
        else
        begin
            n_elem = $urandom_range(1, 8);
            for (int i = 0; i < n_elem; i++)
            begin
                pick = $urandom_range(0, 19);
                if (pick <= 5 || (pick <= 10 && open_codes.size() == 0))
                begin
                    add_open($urandom_range(0, htnc_pkg::NUM_TAGS - 1));
                end
                else if (pick <= 10)
                begin
                    add_text({"</", known_names[open_codes.pop_back()], ">"}, 1'b1);
                end
                else if (pick <= 14)
                begin
                    repeat ($urandom_range(1, 4))
                    begin
                        v = 8'($urandom_range(0, 255));
                        add_byte(v == htnc_pkg::CHAR_LT ? 8'h74 : v);
                    end
                end
                else if (pick <= 16)
                begin
                    add_text("<br/>", 1'b1);
                end
                else if (pick == 17)
                begin
                    c = $urandom_range(0, htnc_pkg::NUM_TAGS - 1);
                    if (open_codes.size() != 0)
                    begin
                        c = (open_codes[$] + $urandom_range(1, htnc_pkg::NUM_TAGS - 1)) %
                            htnc_pkg::NUM_TAGS;
                    end
                    add_text({"</", known_names[c], ">"}, 1'b1);
                end
                else if (pick == 18)
                begin
                    add_text(odd_tags[$urandom_range(0, 8)], 1'b1);
                end
                else
                begin
                    add_byte(htnc_pkg::CHAR_LT);
                    repeat ($urandom_range(0, 18))
                    begin
                        v = 8'($urandom_range(0, 255));
                        add_byte(v == htnc_pkg::CHAR_GT ? 8'h71 : v);
                    end
                    add_byte(htnc_pkg::CHAR_GT);
                end
            end
        end
        if ($urandom_range(0, 19) != 0)
        begin
            while (open_codes.size() != 0)
            begin
                add_text({"</", known_names[open_codes.pop_back()], ">"}, 1'b1);
            end
        end
        pick = $urandom_range(0, 19);
        if (pick == 0)
        begin
            add_byte(htnc_pkg::CHAR_LT);
            add_text(known_names[$urandom_range(0, htnc_pkg::NUM_TAGS - 1)], 1'b1);
        end
        else if (pick == 1)
        begin
            repeat ($urandom_range(1, 6))
            begin
                add_byte(8'($urandom_range(0, 255)));
            end
        end
        else if (pick <= 3)
        begin
            add_byte($urandom_range(0, 1) ? htnc_pkg::CHAR_SPACE : htnc_pkg::CHAR_NL);
        end
        if (doc_bytes.size() == 0)
        begin
            add_byte(8'h61);
        end
        ship_doc();
    endfunction

    // stimulus
    initial
    begin
        int n_docs;
        // empty tag, whitespace last byte
        add_text("<Br/>\n", 1'b0);
        ship_doc();
        // document ends inside a tag
        add_text("<h2", 1'b0);
        ship_doc();
        // closer on empty stack, completed by the last byte
        add_text("</OL>", 1'b0);
        ship_doc();
        // stray '<' inside a tag, then bytes after the error
        add_text("<<>", 1'b0);
        add_byte(8'hFF);
        ship_doc();
        // tag longer than the text buffer
        add_text("<header>", 1'b0);
        ship_doc();
        add_text("<p></ol>", 1'b0);
        ship_doc();
        // unclosed open tag
        add_text("<P>", 1'b0);
        add_byte(8'h00);
        ship_doc();
        n_docs = 0;
        while (beats_to_send.size() < 1100 || n_docs < 60)
        begin
            gen_document();
            n_docs++;
        end
        cycle_limit = 100 * beats_to_send.size() + 20000;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        while (beats_to_send.size() != 0 || s_tvalid || verdicts_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);
        if (fault_cnt == 0 && verdicts_due.size() == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // byte driver
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= 8'h00;
            s_tlast  <= 1'b0;
            send_gap <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                predict_nesting(s_tdata, s_tlast);
            end
            if (!s_tvalid || s_tready)
            begin
                if (send_gap > 0)
                begin
                    s_tvalid <= 1'b0;
                    send_gap <= send_gap - 1;
                end
                else if (beats_to_send.size() != 0)
                begin
                    nxt_beat = beats_to_send.pop_front();
                    s_tdata  <= nxt_beat.data;
                    s_tlast  <= nxt_beat.last;
                    s_tvalid <= 1'b1;
                    if ($urandom_range(0, 59) == 0)
                    begin
                        calm_in = !calm_in;
                    end
                    send_gap <= calm_in ? 0 : $urandom_range(0, 8);
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_tready  <= 1'b0;
            sink_hold <= 0;
        end
        else if (m_tvalid && m_tready)
        begin
            got = htnc_pkg::result_t'(m_tdata[$bits(htnc_pkg::result_t)-1:0]);
            if (verdicts_due.size() == 0)
            begin
                note_fault($sformatf("unexpected result beat %h", got));
            end
            else
            begin
                want = verdicts_due.pop_front();
                if (got.is_valid !== want.is_valid || got.error_kind !== want.error_kind ||
                    got.error_position !== want.error_position ||
                    got.error_tag !== want.error_tag || got.open_count !== want.open_count)
                begin
                    note_fault({
                        $sformatf("mismatch exp valid=%0d kind=%0d pos=%0d tag=%0d open=%0d",
                                  want.is_valid, want.error_kind, want.error_position,
                                  want.error_tag, want.open_count),
                        $sformatf(", got valid=%0d kind=%0d pos=%0d tag=%0d open=%0d",
                                  got.is_valid, got.error_kind, got.error_position,
                                  got.error_tag, got.open_count)});
                end
            end
            if ($urandom_range(0, 19) == 0)
            begin
                calm_out = !calm_out;
            end
            stall = calm_out ? 0 : $urandom_range(0, 8);
            if (stall > 0)
            begin
                m_tready  <= 1'b0;
                sink_hold <= stall;
            end
        end
        else if (!m_tready)
        begin
            if (sink_hold <= 1)
            begin
                m_tready <= 1'b1;
            end
            sink_hold <= sink_hold - 1;
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > cycle_limit)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

endmodule

/* filelist.f */
hdl/htnc_pkg.sv
hdl/htnc_cell.sv
hdl/htnc_stack.sv
hdl/htnc_out_queue.sv
hdl/html_tag_nesting_checker.sv
test/tb.sv
